[design/mtl_pkg.sv]
`timescale 1ns / 1ps

package mtl_pkg;

    // Table geometry
    localparam int TABLE_DEPTH       = 256;
    localparam int RECORDS_PER_FRAME = 64;
    localparam int ADDR_W            = $clog2(TABLE_DEPTH);
    localparam int LEN_W             = $clog2(TABLE_DEPTH + 1);
    localparam int PEND_W            = $clog2(RECORDS_PER_FRAME + 1);
    localparam int NUM_LEVELS        = 4;

    // A length at or above this counts as an empty table
    localparam int EMPTY_LEN = 240;

    // Header magic bytes
    localparam logic [7:0] MAGIC0 = 8'hEC;
    localparam logic [7:0] MAGIC1 = 8'h98;
    localparam logic [7:0] MAGIC3 = 8'hAA;

    // Window size thresholds
    localparam logic [11:0] WIN_W_BIG = 12'd380;
    localparam logic [11:0] WIN_H_BIG = 12'd300;
    localparam logic [11:0] WIN_MIN   = 12'd4;

    // Request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Starting levels
    localparam logic [1:0] LVL_LOW  = 2'd0;
    localparam logic [1:0] LVL_HIGH = 2'd3;

    // Quadrant windows in tile units
    localparam logic [7:0] QUAD_LO_MAX  = 8'd7;
    localparam logic [7:0] COL_HI_MIN   = 8'd11;
    localparam logic [7:0] COL_HI_MAX   = 8'd19;
    localparam logic [7:0] ROW_HI_MIN   = 8'd19;
    localparam logic [7:0] ROW_HI_MAX   = 8'd26;

    // Source frame codes
    localparam logic [1:0] SRC_NONE   = 2'd0;
    localparam logic [1:0] SRC_TOP_L  = 2'd1;
    localparam logic [1:0] SRC_BOT_R  = 2'd2;
    localparam logic [1:0] SRC_BOT_L  = 2'd3;

    // Tile and frame sizes in pixels
    localparam logic [15:0] TILE_W  = 16'd240;
    localparam logic [15:0] TILE_H  = 16'd136;
    localparam logic [16:0] FRAME_W = 17'd1920;
    localparam logic [16:0] FRAME_H = 17'd1080;

    typedef struct packed {
        logic        req_type;
        logic [6:0]  rec_index;
        logic        new_set;
        logic [7:0]  rec_byte0;
        logic [7:0]  rec_byte1;
        logic [7:0]  rec_byte2;
        logic [7:0]  rec_byte3;
        logic [7:0]  chid;
        logic [11:0] win_width;
        logic [11:0] win_height;
    } mtl_in_t;

    typedef struct packed {
        logic [1:0]  source_sel;
        logic [15:0] crop_x;
        logic [15:0] crop_y;
        logic [10:0] crop_width;
        logic [10:0] crop_height;
        logic [1:0]  level_used;
        logic        found;
    } mtl_out_t;

    // Controller to datapath
    typedef struct packed {
        logic load_en;
        logic query_en;
        logic rd_en;
        logic sel_en;
        logic out_load;
    } mtl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_query;
        logic small_win;
        logic tbl_empty;
        logic last_addr;
        logic out_free;
    } mtl_sts_t;

    function automatic logic [10:0] level_width(input logic [1:0] lvl);
        logic [10:0] w;
        unique case (lvl)
            2'd0:    w = 11'd240;
            2'd1:    w = 11'd480;
            2'd2:    w = 11'd960;
            default: w = 11'd1920;
        endcase
        return w;
    endfunction

    function automatic logic [10:0] level_height(input logic [1:0] lvl);
        logic [10:0] h;
        unique case (lvl)
            2'd0:    h = 11'd136;
            2'd1:    h = 11'd270;
            2'd2:    h = 11'd540;
            default: h = 11'd1080;
        endcase
        return h;
    endfunction

endpackage

[design/mosaic_tile_locator_unit.sv]
`timescale 1ns / 1ps

// Mosaic tile locator. Load words (req_type 0) fill a position table from
// per-frame header records. A query word (req_type 1) scans the table once
// through a single read port, one entry per cycle, keeping the first hit on
// the channel for every level, and then returns the crop rectangle of the best
// level at or below the starting one. After the scan a query passes through a
// drain and a select state (an empty table skips the scan and drain) and waits
// for the result register to drain before the next word can be taken; a query
// whose window is under 4 pixels wide or high is dropped without a result. The
// block takes one word at a time, and a finished result waits in its own output
// register while loads continue.
module mosaic_tile_locator_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mtl_pkg::mtl_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mtl_pkg::mtl_out_t m_data
);

    mtl_pkg::mtl_cmd_t cmd;
    mtl_pkg::mtl_sts_t sts;

    // Sequence loads and queries
    mtl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Table, scan and crop arithmetic
    mtl_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[design/mtl_ctrl.sv]
`timescale 1ns / 1ps

module mtl_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mtl_pkg::mtl_sts_t sts,
    output mtl_pkg::mtl_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_SEL,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;
    logic   accept;

    assign accept  = s_valid && s_ready_reg;
    assign s_ready = s_ready_reg;

    // Decode commands and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!sts.is_query) begin
                        cmd.load_en = 1'b1;
                    end else if (!sts.small_win) begin
                        cmd.query_en = 1'b1;
                        state_next   = sts.tbl_empty ? ST_SEL : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
                if (sts.last_addr) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_SEL;
            end
            ST_SEL: begin
                cmd.sel_en = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state and the ready flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

[design/mtl_dpath.sv]
`timescale 1ns / 1ps

module mtl_dpath (
    input  logic              aclk,
    input  logic              aresetn,
    input  mtl_pkg::mtl_in_t  s_data,
    input  mtl_pkg::mtl_cmd_t cmd,
    output mtl_pkg::mtl_sts_t sts,
    output logic              m_valid,
    input  logic              m_ready,
    output mtl_pkg::mtl_out_t m_data
);

    localparam int ADDR_W = mtl_pkg::ADDR_W;
    localparam int LEN_W  = mtl_pkg::LEN_W;
    localparam int PEND_W = mtl_pkg::PEND_W;
    localparam int NLV    = mtl_pkg::NUM_LEVELS;

    // Position table
    logic [31:0] mem [mtl_pkg::TABLE_DEPTH];
    logic [31:0] rd_data_reg;

    logic [LEN_W-1:0]  len_reg, len_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [ADDR_W-1:0] idx_reg;
    logic              wr_en;
    logic              is_header;
    logic              magic_ok;

    // Query context
    logic [7:0]        chid_reg;
    logic [1:0]        start_reg;
    logic              empty_reg;
    logic              cmp_vld_reg;
    logic [NLV-1:0]    hit_reg;
    logic [7:0]        hcol_reg [NLV];
    logic [7:0]        hrow_reg [NLV];
    logic              match;
    logic [1:0]        match_lvl;

    // Selection stage
    logic [1:0]        sel_lvl;
    logic              sel_found;
    logic [7:0]        sel_col;
    logic [7:0]        sel_row;
    logic [7:0]        fcol;
    logic [7:0]        frow;
    logic [1:0]        fsrc;
    logic              col_lo, col_hi, row_lo, row_hi;
    logic [1:0]        lvl_reg;
    logic              found_reg;
    logic [7:0]        col_f_reg;
    logic [7:0]        row_f_reg;
    logic [1:0]        src_reg;

    // Output stage
    logic [15:0]       px;
    logic [15:0]       py;
    logic [10:0]       pw;
    logic [10:0]       ph;
    logic              m_valid_reg;
    mtl_pkg::mtl_out_t m_data_reg;

    // Status towards the controller
    assign sts.is_query  = (s_data.req_type == mtl_pkg::REQ_QUERY);
    assign sts.small_win = (s_data.win_width < mtl_pkg::WIN_MIN) ||
                           (s_data.win_height < mtl_pkg::WIN_MIN);
    assign sts.tbl_empty = (len_reg == '0) || (32'(len_reg) >= mtl_pkg::EMPTY_LEN);
    assign sts.last_addr = ((LEN_W'(idx_reg) + LEN_W'(1)) == len_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;

    // Decode a load word
    assign is_header = (s_data.rec_index == 7'd0);
    assign magic_ok  = (s_data.rec_byte0 == mtl_pkg::MAGIC0) &&
                       (s_data.rec_byte1 == mtl_pkg::MAGIC1) &&
                       (s_data.rec_byte3 == mtl_pkg::MAGIC3);
    assign wr_en     = cmd.load_en && !is_header && (pend_reg != '0) &&
                       (32'(len_reg) < mtl_pkg::TABLE_DEPTH);

    always_comb begin
        len_next  = len_reg;
        pend_next = pend_reg;
        if (cmd.load_en) begin
            if (is_header) begin
                if (s_data.new_set) begin
                    len_next = '0;
                end
                if (!magic_ok) begin
                    pend_next = '0;
                end else if (32'(s_data.rec_byte2) > mtl_pkg::RECORDS_PER_FRAME) begin
                    pend_next = PEND_W'(mtl_pkg::RECORDS_PER_FRAME);
                end else begin
                    pend_next = PEND_W'(s_data.rec_byte2);
                end
            end else if (pend_reg != '0) begin
                pend_next = pend_reg - PEND_W'(1);
                if (wr_en) begin
                    len_next = len_reg + LEN_W'(1);
                end
            end
        end
    end

    // Hold length and pending count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            pend_reg <= '0;
        end else begin
            len_reg  <= len_next;
            pend_reg <= pend_next;
        end
    end

    // Write and read the table
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[len_reg[ADDR_W-1:0]] <= {s_data.rec_byte3, s_data.rec_byte2,
                                         s_data.rec_byte1, s_data.rec_byte0};
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // Compare the word read in the previous cycle
    assign match_lvl = rd_data_reg[9:8];
    assign match     = cmp_vld_reg && (rd_data_reg[7:0] == chid_reg) &&
                       (rd_data_reg[15:10] == 6'd0) && !hit_reg[match_lvl];

    // Scan control and first hit per level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_vld_reg <= 1'b0;
            hit_reg     <= '0;
            idx_reg     <= '0;
        end else begin
            cmp_vld_reg <= cmd.rd_en;
            if (cmd.query_en) begin
                hit_reg <= '0;
                idx_reg <= '0;
            end else begin
                if (cmd.rd_en) begin
                    idx_reg <= idx_reg + ADDR_W'(1);
                end
                if (match) begin
                    hit_reg[match_lvl] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.query_en) begin
            chid_reg  <= s_data.chid;
            empty_reg <= sts.tbl_empty;
            start_reg <= ((s_data.win_width >= mtl_pkg::WIN_W_BIG) ||
                          (s_data.win_height >= mtl_pkg::WIN_H_BIG)) ?
                         mtl_pkg::LVL_HIGH : mtl_pkg::LVL_LOW;
        end
        if (match) begin
            hcol_reg[match_lvl] <= rd_data_reg[23:16];
            hrow_reg[match_lvl] <= rd_data_reg[31:24];
        end
    end

    // Pick the highest level hit at or below the starting level
    always_comb begin
        sel_found = 1'b0;
        sel_lvl   = empty_reg ? mtl_pkg::LVL_LOW : start_reg;
        sel_col   = 8'd0;
        sel_row   = 8'd0;
        for (int lv = 0; lv < NLV; lv++) begin
            if ((2'(lv) <= start_reg) && hit_reg[lv]) begin
                sel_found = 1'b1;
                sel_lvl   = 2'(lv);
                sel_col   = hcol_reg[lv];
                sel_row   = hrow_reg[lv];
            end
        end
    end

    // Fold the tile into its source quadrant
    assign col_lo = (sel_col <= mtl_pkg::QUAD_LO_MAX);
    assign col_hi = (sel_col >= mtl_pkg::COL_HI_MIN) && (sel_col <= mtl_pkg::COL_HI_MAX);
    assign row_lo = (sel_row <= mtl_pkg::QUAD_LO_MAX);
    assign row_hi = (sel_row >= mtl_pkg::ROW_HI_MIN) && (sel_row <= mtl_pkg::ROW_HI_MAX);

    always_comb begin
        fcol = sel_col;
        frow = sel_row;
        fsrc = mtl_pkg::SRC_NONE;
        priority if (col_lo && row_lo) begin
            fsrc = mtl_pkg::SRC_TOP_L;
        end else if (col_hi && row_lo) begin
            fcol = sel_col - mtl_pkg::COL_HI_MIN;
        end else if (col_lo && row_hi) begin
            frow = sel_row - mtl_pkg::ROW_HI_MIN;
            fsrc = mtl_pkg::SRC_BOT_L;
        end else if (col_hi && row_hi) begin
            fcol = sel_col - mtl_pkg::COL_HI_MIN;
            frow = sel_row - mtl_pkg::ROW_HI_MIN;
            fsrc = mtl_pkg::SRC_BOT_R;
        end else begin
            fsrc = mtl_pkg::SRC_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sel_en) begin
            lvl_reg   <= sel_lvl;
            found_reg <= sel_found;
            col_f_reg <= fcol;
            row_f_reg <= frow;
            src_reg   <= fsrc;
        end
    end

    // Crop rectangle, clamped to the frame
    assign px = 16'({8'd0, col_f_reg} * mtl_pkg::TILE_W);
    assign py = 16'({8'd0, row_f_reg} * mtl_pkg::TILE_H);

    always_comb begin
        pw = mtl_pkg::level_width(lvl_reg);
        ph = mtl_pkg::level_height(lvl_reg);
        if ((17'(px) + 17'(pw)) > mtl_pkg::FRAME_W) begin
            pw = (17'(px) >= mtl_pkg::FRAME_W) ? 11'd0 : 11'(mtl_pkg::FRAME_W - 17'(px));
        end
        if ((17'(py) + 17'(ph)) > mtl_pkg::FRAME_H) begin
            ph = (17'(py) >= mtl_pkg::FRAME_H) ? 11'd0 : 11'(mtl_pkg::FRAME_H - 17'(py));
        end
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.source_sel  <= src_reg;
            m_data_reg.crop_x      <= px;
            m_data_reg.crop_y      <= py;
            m_data_reg.crop_width  <= pw;
            m_data_reg.crop_height <= ph;
            m_data_reg.level_used  <= lvl_reg;
            m_data_reg.found       <= found_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A new word never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid_reg && !m_ready))
        else $error("result word overwritten before it was taken");

    // The table never grows past its depth
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(len_reg) <= mtl_pkg::TABLE_DEPTH)
        else $error("table length beyond depth");

    // A body record uses up exactly one pending slot
    a_pend_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_en && !is_header && (pend_reg != '0)) |=>
            (pend_reg == $past(pend_reg) - PEND_W'(1)))
        else $error("pending count not decremented");

    // The table stays put while it is being scanned
    a_len_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |=> $stable(len_reg))
        else $error("table length moved during a scan");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

// Shadow of the position table and the queue of crop words still owed
class crop_board;
    logic [31:0]       tiles [mtl_pkg::TABLE_DEPTH];
    int unsigned       tile_count;
    int unsigned       records_left;
    mtl_pkg::mtl_out_t crops [$];
    int unsigned       errors;
    int unsigned       useful;

    function new();
        tile_count   = 0;
        records_left = 0;
        errors       = 0;
        useful       = 0;
    endfunction

    // Apply one accepted input word and queue the crop it owes, if any
    function void take_word(mtl_pkg::mtl_in_t w);
        logic [1:0]        lvl;
        logic [1:0]        sel;
        logic [7:0]        col;
        logic [7:0]        row;
        logic              hit;
        int                x;
        int                y;
        int                wd;
        int                ht;
        mtl_pkg::mtl_out_t r;

        // Load path: header arms the loader, body words append entries
        if (w.req_type == mtl_pkg::REQ_LOAD) begin
            if (w.rec_index == 0) begin
                useful++;
                if (w.new_set)
                    tile_count = 0;
                if (w.rec_byte0 == mtl_pkg::MAGIC0 && w.rec_byte1 == mtl_pkg::MAGIC1 &&
                    w.rec_byte3 == mtl_pkg::MAGIC3)
                    records_left = (w.rec_byte2 > mtl_pkg::RECORDS_PER_FRAME) ?
                                   mtl_pkg::RECORDS_PER_FRAME : w.rec_byte2;
                else
                    records_left = 0;
            end else if (records_left != 0) begin
                useful++;
                records_left--;
                if (tile_count < mtl_pkg::TABLE_DEPTH) begin
                    tiles[tile_count] = {w.rec_byte3, w.rec_byte2, w.rec_byte1, w.rec_byte0};
                    tile_count++;
                end
            end
            return;
        end

        useful++;
        lvl = (w.win_width >= mtl_pkg::WIN_W_BIG || w.win_height >= mtl_pkg::WIN_H_BIG) ?
              mtl_pkg::LVL_HIGH : mtl_pkg::LVL_LOW;
        col = 8'd0;
        row = 8'd0;
        hit = 1'b0;

        // Search from the starting level downwards for the first channel match
        if (tile_count == 0 || tile_count >= mtl_pkg::EMPTY_LEN) begin
            lvl = mtl_pkg::LVL_LOW;
        end else begin
            for (int lv = lvl; lv >= 0 && !hit; lv--) begin
                for (int i = 0; i < tile_count && !hit; i++) begin
                    if (tiles[i][7:0] == w.chid && tiles[i][15:8] == lv) begin
                        col = tiles[i][23:16];
                        row = tiles[i][31:24];
                        lvl = 2'(lv);
                        hit = 1'b1;
                    end
                end
            end
        end

        // Fold the tile into its source quadrant; top right folds but selects none
        if (col <= mtl_pkg::QUAD_LO_MAX && row <= mtl_pkg::QUAD_LO_MAX) begin
            sel = mtl_pkg::SRC_TOP_L;
        end else if (col >= mtl_pkg::COL_HI_MIN && col <= mtl_pkg::COL_HI_MAX &&
                     row <= mtl_pkg::QUAD_LO_MAX) begin
            col = col - mtl_pkg::COL_HI_MIN;
            sel = mtl_pkg::SRC_NONE;
        end else if (col <= mtl_pkg::QUAD_LO_MAX && row >= mtl_pkg::ROW_HI_MIN &&
                     row <= mtl_pkg::ROW_HI_MAX) begin
            row = row - mtl_pkg::ROW_HI_MIN;
            sel = mtl_pkg::SRC_BOT_L;
        end else if (col >= mtl_pkg::COL_HI_MIN && col <= mtl_pkg::COL_HI_MAX &&
                     row >= mtl_pkg::ROW_HI_MIN && row <= mtl_pkg::ROW_HI_MAX) begin
            col = col - mtl_pkg::COL_HI_MIN;
            row = row - mtl_pkg::ROW_HI_MIN;
            sel = mtl_pkg::SRC_BOT_R;
        end else begin
            sel = mtl_pkg::SRC_NONE;
        end

        // Drop tiny windows
        if (w.win_width < mtl_pkg::WIN_MIN || w.win_height < mtl_pkg::WIN_MIN)
            return;

        case (lvl)
            2'd0: begin wd = 240;  ht = 136;  end
            2'd1: begin wd = 480;  ht = 270;  end
            2'd2: begin wd = 960;  ht = 540;  end
            default: begin wd = 1920; ht = 1080; end
        endcase

        // Clamp the crop to the frame, saturating at zero
        x = int'(col) * int'(mtl_pkg::TILE_W);
        y = int'(row) * int'(mtl_pkg::TILE_H);
        if (x + wd > int'(mtl_pkg::FRAME_W))
            wd = (x >= int'(mtl_pkg::FRAME_W)) ? 0 : int'(mtl_pkg::FRAME_W) - x;
        if (y + ht > int'(mtl_pkg::FRAME_H))
            ht = (y >= int'(mtl_pkg::FRAME_H)) ? 0 : int'(mtl_pkg::FRAME_H) - y;

        r.source_sel  = sel;
        r.crop_x      = x[15:0];
        r.crop_y      = y[15:0];
        r.crop_width  = wd[10:0];
        r.crop_height = ht[10:0];
        r.level_used  = lvl;
        r.found       = hit;
        crops.push_back(r);
    endfunction

    function void field_check(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Compare one crop word from the block against the oldest one owed
    function void check_crop(mtl_pkg::mtl_out_t got);
        mtl_pkg::mtl_out_t want;
        if (crops.size() == 0) begin
            $error("crop word %h with none outstanding", got);
            errors++;
            return;
        end
        want = crops.pop_front();
        field_check("source_sel",  16'(want.source_sel),  16'(got.source_sel));
        field_check("crop_x",      want.crop_x,           got.crop_x);
        field_check("crop_y",      want.crop_y,           got.crop_y);
        field_check("crop_width",  16'(want.crop_width),  16'(got.crop_width));
        field_check("crop_height", 16'(want.crop_height), 16'(got.crop_height));
        field_check("level_used",  16'(want.level_used),  16'(got.level_used));
        field_check("found",       16'(want.found),       16'(got.found));
    endfunction
endclass

module testbench;

    localparam int ITEMS          = 2000;
    localparam int QUIET_ITEMS    = 250;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 300;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    mtl_pkg::mtl_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    mtl_pkg::mtl_out_t m_data;

    crop_board board = new();

    int gap_pct;
    bit quiet;
    int fill;

    mosaic_tile_locator_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Note accepted words on both channels
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            board.take_word(s_data);
        if (aresetn && m_valid && m_ready)
            board.check_crop(m_data);
    end

    // Watchdog: give up after a long stretch with no word moving
    initial begin
        int unsigned stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    // Result side: long ready stretches broken by short stalls
    initial begin
        int hold;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 1500) :
                                                 $urandom_range(1, 30);
            m_ready <= 1'b1;
            repeat (hold) @(posedge aclk);
            if (!quiet) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
    end

    // Offer one word, with an optional idle burst first, and hold until taken
    task automatic send_word(input mtl_pkg::mtl_in_t w);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic mtl_pkg::mtl_in_t load_word(input logic [6:0] idx, input logic ns,
                                                   input logic [7:0] b0, input logic [7:0] b1,
                                                   input logic [7:0] b2, input logic [7:0] b3);
        mtl_pkg::mtl_in_t w;
        w.req_type   = mtl_pkg::REQ_LOAD;
        w.rec_index  = idx;
        w.new_set    = ns;
        w.rec_byte0  = b0;
        w.rec_byte1  = b1;
        w.rec_byte2  = b2;
        w.rec_byte3  = b3;
        w.chid       = 8'($urandom_range(0, 255));
        w.win_width  = 12'($urandom_range(0, 4095));
        w.win_height = 12'($urandom_range(0, 4095));
        return w;
    endfunction

    function automatic mtl_pkg::mtl_in_t query_word(input logic [7:0] ch,
                                                    input logic [11:0] ww,
                                                    input logic [11:0] wh);
        mtl_pkg::mtl_in_t w;
        w.req_type   = mtl_pkg::REQ_QUERY;
        w.rec_index  = 7'($urandom_range(0, 64));
        w.new_set    = 1'($urandom_range(0, 1));
        w.rec_byte0  = 8'($urandom_range(0, 255));
        w.rec_byte1  = 8'($urandom_range(0, 255));
        w.rec_byte2  = 8'($urandom_range(0, 255));
        w.rec_byte3  = 8'($urandom_range(0, 255));
        w.chid       = ch;
        w.win_width  = ww;
        w.win_height = wh;
        return w;
    endfunction

    // Tile coordinate biased towards the quadrant windows and their borders
    function automatic logic [7:0] pick_tile(input bit is_row);
        logic [7:0] col_edges [6] = '{8'd7, 8'd8, 8'd10, 8'd11, 8'd19, 8'd20};
        logic [7:0] row_edges [6] = '{8'd7, 8'd8, 8'd18, 8'd19, 8'd26, 8'd27};
        logic [7:0] v;
        case ($urandom_range(0, 5))
            0: v = 8'($urandom_range(0, 7));
            1: v = is_row ? 8'($urandom_range(19, 26)) : 8'($urandom_range(11, 19));
            2: v = is_row ? 8'($urandom_range(8, 18)) : 8'($urandom_range(8, 10));
            3: v = is_row ? 8'($urandom_range(27, 255)) : 8'($urandom_range(20, 255));
            4: v = is_row ? row_edges[$urandom_range(0, 5)] : col_edges[$urandom_range(0, 5)];
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    // Window span around the tiny and big thresholds
    function automatic logic [11:0] pick_span(input int big);
        int r;
        logic [11:0] v;
        r = $urandom_range(0, 19);
        if (r == 0)
            v = 12'($urandom_range(0, 3));
        else if (r <= 3)
            case ($urandom_range(0, 4))
                0: v = 12'd3;
                1: v = 12'd4;
                2: v = 12'(big - 1);
                3: v = 12'(big);
                default: v = 12'd4095;
            endcase
        else if (r <= 11)
            v = 12'($urandom_range(4, big - 1));
        else
            v = 12'($urandom_range(big, 4095));
        return v;
    endfunction

    task automatic send_body();
        send_word(load_word(7'($urandom_range(1, 64)), 1'($urandom_range(0, 1)),
                            ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 3)) :
                                                          8'($urandom_range(0, 255)),
                            ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3)) :
                                                          8'($urandom_range(0, 255)),
                            pick_tile(1'b0), pick_tile(1'b1)));
    endtask

    task automatic send_query();
        send_word(query_word(($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 3)) :
                                                           8'($urandom_range(0, 255)),
                             pick_span(int'(mtl_pkg::WIN_W_BIG)),
                             pick_span(int'(mtl_pkg::WIN_H_BIG))));
    endtask

    // Header word; a bad one has a single magic byte corrupted
    task automatic send_header(input bit ns, input logic [7:0] count, input bit good);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b3;
        b0 = mtl_pkg::MAGIC0;
        b1 = mtl_pkg::MAGIC1;
        b3 = mtl_pkg::MAGIC3;
        if (!good)
            case ($urandom_range(0, 2))
                0: b0 = b0 ^ 8'($urandom_range(1, 255));
                1: b1 = b1 ^ 8'($urandom_range(1, 255));
                default: b3 = b3 ^ 8'($urandom_range(1, 255));
            endcase
        if (ns)
            fill = 0;
        send_word(load_word(7'd0, ns, b0, b1, count, b3));
    endtask

    // One frame: header, body words (sometimes short or overlong) with the odd query among them, then queries
    task automatic send_frame();
        bit ns;
        bit good;
        int count;
        int eff;
        int nbody;
        int pick;
        if (fill >= mtl_pkg::EMPTY_LEN)
            ns = 1'($urandom_range(0, 1));
        else if (fill > 200)
            ns = ($urandom_range(0, 3) != 0);
        else
            ns = ($urandom_range(0, 5) == 0);
        good = ($urandom_range(0, 99) < 85);
        pick = $urandom_range(0, 9);
        if (pick < 7)
            count = $urandom_range(0, 10);
        else if (pick < 9)
            count = $urandom_range(11, mtl_pkg::RECORDS_PER_FRAME);
        else
            count = $urandom_range(mtl_pkg::RECORDS_PER_FRAME + 1, 255);
        eff = good ? ((count > mtl_pkg::RECORDS_PER_FRAME) ?
                      mtl_pkg::RECORDS_PER_FRAME : count) : 0;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            nbody = $urandom_range(0, eff);
        else if (pick < 25)
            nbody = eff + $urandom_range(1, 3);
        else
            nbody = eff;
        send_header(ns, 8'(count), good);
        for (int i = 0; i < nbody; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_query();
            send_body();
            if (i < eff && fill < mtl_pkg::TABLE_DEPTH)
                fill++;
        end
        repeat ($urandom_range(1, 4)) send_query();
    endtask

    // Grow the table from empty up to a target length, querying along the way
    task automatic fill_deep(input int target);
        int loaded;
        int left;
        int c;
        loaded = 0;
        while (loaded < target) begin
            left = target - loaded;
            c = (left >= mtl_pkg::RECORDS_PER_FRAME) ? mtl_pkg::RECORDS_PER_FRAME : left;
            send_header(loaded == 0,
                        (left >= mtl_pkg::RECORDS_PER_FRAME) ?
                            8'($urandom_range(mtl_pkg::RECORDS_PER_FRAME, 255)) : 8'(left),
                        1'b1);
            repeat (c) send_body();
            loaded += c;
            if ($urandom_range(0, 1))
                send_query();
        end
        fill = (loaded > mtl_pkg::TABLE_DEPTH) ? mtl_pkg::TABLE_DEPTH : loaded;
        repeat (3) send_query();
    endtask

    // Hold off the sender until every owed crop word has arrived
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.crops.size() != 0) @(posedge aclk);
    endtask

    // Stimulus
    initial begin
        int frame_no;
        s_valid <= 1'b0;
        s_data  <= '0;
        aresetn <= 1'b0;
        gap_pct = 20;
        quiet   = 1'b0;
        fill    = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table and tiny windows
        send_word(query_word(8'd0, 12'd1920, 12'd1080));
        send_word(query_word(8'd0, 12'd3, 12'd4095));
        send_word(query_word(8'd0, 12'd4095, 12'd3));
        send_word(query_word(8'd0, 12'd4, 12'd4));
        // Body with nothing armed, then a bad header that still clears
        send_word(load_word(7'd5, 1'b0, 8'd1, 8'd0, 8'd3, 8'd2));
        send_word(load_word(7'd0, 1'b1, mtl_pkg::MAGIC0, 8'h99, 8'd5, mtl_pkg::MAGIC3));
        send_word(load_word(7'd1, 1'b0, 8'd1, 8'd0, 8'd3, 8'd2));
        // Six entries covering every quadrant and the outside case
        send_word(load_word(7'd0, 1'b1, mtl_pkg::MAGIC0, mtl_pkg::MAGIC1, 8'd6,
                            mtl_pkg::MAGIC3));
        send_word(load_word(7'd1, 1'b0, 8'd1, 8'd0, 8'd3, 8'd2));
        send_word(load_word(7'd2, 1'b1, 8'd1, 8'd3, 8'd15, 8'd5));
        send_word(load_word(7'd3, 1'b0, 8'd2, 8'd2, 8'd5, 8'd22));
        send_word(load_word(7'd4, 1'b0, 8'd2, 8'd1, 8'd12, 8'd20));
        send_word(load_word(7'd5, 1'b0, 8'd3, 8'd3, 8'd9, 8'd9));
        send_word(load_word(7'd64, 1'b0, 8'd255, 8'd255, 8'd255, 8'd255));
        fill = 6;
        // Level selection, fallback and misses
        send_word(query_word(8'd1, 12'd380, 12'd4));
        send_word(query_word(8'd1, 12'd379, 12'd299));
        send_word(query_word(8'd2, 12'd4095, 12'd4095));
        send_word(query_word(8'd3, 12'd4, 12'd300));
        send_word(query_word(8'd9, 12'd2000, 12'd2000));
        send_word(query_word(8'd255, 12'd4095, 12'd4095));
        // Oversized count, zero count, and a stray body
        send_word(load_word(7'd0, 1'b0, mtl_pkg::MAGIC0, mtl_pkg::MAGIC1, 8'd255,
                            mtl_pkg::MAGIC3));
        send_word(load_word(7'd0, 1'b0, mtl_pkg::MAGIC0, mtl_pkg::MAGIC1, 8'd0,
                            mtl_pkg::MAGIC3));
        send_word(load_word(7'd9, 1'b0, 8'd1, 8'd0, 8'd0, 8'd0));
        send_word(query_word(8'd1, 12'd100, 12'd100));
        drain();

        // Random frames
        frame_no = 0;
        while (board.useful < ITEMS) begin
            quiet = (board.useful + QUIET_ITEMS >= ITEMS);
            case ($urandom_range(0, 3))
                0: gap_pct = 0;
                1: gap_pct = 5;
                2: gap_pct = 20;
                default: gap_pct = 50;
            endcase
            if (frame_no == 5)
                fill_deep(300);
            else if (frame_no == 60)
                fill_deep(239);
            else if ($urandom_range(0, 299) == 0)
                fill_deep($urandom_range(200, 300));
            else
                send_frame();
            if ($urandom_range(0, 49) == 0)
                drain();
            frame_no++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.crops.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
